### design/mrct_pkg.sv
// Shared types and constants of the multiplexer receive connection table.
// Used by mrct_mem, mrct_ctrl and mux_receive_connection_table.
`timescale 1ns / 1ps
`default_nettype none

package mrct_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned CNT_W = $clog2(MAX_RESULTS + 1);

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned IN_TDATA_W = 88;
  localparam int unsigned OUT_TDATA_W = 56;

  localparam logic [7:0] RST_CONNECT_CODE = 8'd1;
  localparam logic [7:0] RST_PUSH_CODE = 8'd2;
  localparam logic [7:0] RST_CLOSE_CODE = 8'd3;
  localparam logic [31:0] RST_IDLE_TIMEOUT = 32'd30000;
  localparam logic RST_TIMEOUT_ENABLE = 1'b1;

  typedef enum logic [2:0] {
    CFG_CONNECT_CODE = 3'd0,
    CFG_PUSH_CODE = 3'd1,
    CFG_CLOSE_CODE = 3'd2,
    CFG_IDLE_TIMEOUT = 3'd3,
    CFG_TIMEOUT_ENABLE = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_MSG = 2'd0,
    OP_TICK = 2'd1,
    OP_RELEASE = 2'd2,
    OP_UNUSED = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_NEW = 2'd0,
    ST_OPEN = 2'd1,
    ST_CLOSED = 2'd2
  } st_e;

  typedef enum logic [3:0] {
    ACT_BAD_CONNECT = 4'd0,
    ACT_DROP = 4'd1,
    ACT_NEW_DELIVER = 4'd2,
    ACT_DELIVER = 4'd3,
    ACT_CLOSED = 4'd4,
    ACT_FULL = 4'd5,
    ACT_RELEASED = 4'd6,
    ACT_REL_MISS = 4'd7,
    ACT_IGNORED = 4'd8
  } act_e;

  typedef struct packed {
    logic [7:0] connect_code;
    logic [7:0] push_code;
    logic [7:0] close_code;
    logic [31:0] idle_timeout;
    logic timeout_enable;
  } cfg_t;

  typedef struct packed {
    op_e opcode;
    logic [7:0] msg_cmd;
    logic [31:0] conn_id;
    logic [15:0] payload_length;
    logic [31:0] time_now;
  } item_t;

  typedef struct packed {
    logic [31:0] id;
    st_e status;
    logic [31:0] rx_time;
  } entry_t;

  typedef struct packed {
    act_e action;
    logic [31:0] result_id;
    logic [3:0] slot;
    logic [15:0] deliver_length;
    logic last;
  } res_t;

endpackage

`default_nettype wire

### design/mux_receive_connection_table.sv
// Receive-side connection table of a stream multiplexer, top level.
// Holds the configuration registers and the output register; uses mrct_pkg,
// mrct_mem and mrct_ctrl.
//
// Usage: each word on the slave stream is one header, tick or release (kind in
// tuser). Results leave on the master stream, action in tuser, tlast on the
// final result of an item. Configuration is written through cfg_we_i, cfg_addr_i
// and cfg_wdata_i by the user only while no item is in flight (not enforced).
// Timing: one item at a time. A header or release walks the whole table in the
// entry memory, reading and then checking each entry; after the scan it picks
// its action, its result reaches the output register as the sequencer returns
// to idle, and the next word is taken from then on. A tick walks the table as
// well, leaves its last result after the scan plus any stall, and may report up
// to 16 closes. A tick with the idle check off and the unused kind skip the
// scan and go straight to the flush step that hands out any result.
// Reset clears all valid bits, so the table starts empty, and loads the
// default configuration. When the receiver stalls, the result waits in the
// output register and one more in the sequencer; a tick's scan halts at an
// expiring entry until it frees; a new item is taken once the last result is in it.
`timescale 1ns / 1ps
`default_nettype none

module mux_receive_connection_table #(
  parameter int unsigned TableDepth = mrct_pkg::TABLE_DEPTH
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [mrct_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  wire logic [mrct_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // msg_cmd, conn_id, payload_length, time_now
  input  wire logic [mrct_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // opcode
  input  wire logic [1:0]                          s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // result_id, slot, deliver_length, zero fill
  output logic [mrct_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
  // action
  output logic [3:0]                               m_axis_tuser,
  output logic                                     m_axis_tlast
);

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;

  mrct_pkg::cfg_t cfg_q, cfg_d;
  logic out_valid_q, out_valid_d;
  mrct_pkg::res_t out_q, out_d;
  mrct_pkg::item_t item;
  mrct_pkg::res_t res;
  logic res_valid;
  logic out_free;
  logic mem_we, mem_re;
  logic [IdxW-1:0] mem_waddr, mem_raddr;
  mrct_pkg::entry_t mem_wdata, mem_rdata;

  assign item.opcode = mrct_pkg::op_e'(s_axis_tuser);
  assign item.msg_cmd = s_axis_tdata[7:0];
  assign item.conn_id = s_axis_tdata[39:8];
  assign item.payload_length = s_axis_tdata[55:40];
  assign item.time_now = s_axis_tdata[87:56];

  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (mrct_pkg::cfg_idx_e'(cfg_addr_i))
        mrct_pkg::CFG_CONNECT_CODE: cfg_d.connect_code = cfg_wdata_i[7:0];
        mrct_pkg::CFG_PUSH_CODE: cfg_d.push_code = cfg_wdata_i[7:0];
        mrct_pkg::CFG_CLOSE_CODE: cfg_d.close_code = cfg_wdata_i[7:0];
        mrct_pkg::CFG_IDLE_TIMEOUT: cfg_d.idle_timeout = cfg_wdata_i[31:0];
        mrct_pkg::CFG_TIMEOUT_ENABLE: cfg_d.timeout_enable = cfg_wdata_i[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d = out_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
      out_d = res;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mrct_pkg::RST_CONNECT_CODE, mrct_pkg::RST_PUSH_CODE,
                 mrct_pkg::RST_CLOSE_CODE, mrct_pkg::RST_IDLE_TIMEOUT,
                 mrct_pkg::RST_TIMEOUT_ENABLE};
      out_valid_q <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  mrct_ctrl #(
    .TableDepth(TableDepth)
  ) u_ctrl (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_i(cfg_q),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .item_i(item),
    .out_free_i(out_free),
    .res_valid_o(res_valid),
    .res_o(res),
    .mem_we_o(mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o(mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  mrct_mem #(
    .TableDepth(TableDepth)
  ) u_mem (
    .clk_i(clk_i),
    .we_i(mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i(mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = {4'b0000, out_q.deliver_length, out_q.slot, out_q.result_id};
  assign m_axis_tuser = out_q.action;
  assign m_axis_tlast = out_q.last;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted again while an item is in work");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> out_free)
    else $error("result overwrote a word not yet taken");

  a_len_only_deliver: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[51:36] != 16'd0) |->
      (m_axis_tuser == mrct_pkg::ACT_NEW_DELIVER) ||
      (m_axis_tuser == mrct_pkg::ACT_DELIVER))
    else $error("deliver length on a result that delivers nothing");

  a_mem_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("entry memory read and written in the same cycle");
`endif

endmodule

`default_nettype wire

### design/mrct_mem.sv
// Synchronous single-write, single-read memory holding the connection entries.
// Entry layout comes from mrct_pkg; read data is registered and appears in the cycle after the read.
`timescale 1ns / 1ps
`default_nettype none

module mrct_mem #(
  parameter int unsigned TableDepth = mrct_pkg::TABLE_DEPTH,
  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [IdxW-1:0]      waddr_i,
  input  wire mrct_pkg::entry_t     wdata_i,
  input  wire logic                 re_i,
  input  wire logic [IdxW-1:0]      raddr_i,
  output mrct_pkg::entry_t          rdata_o
);

  mrct_pkg::entry_t mem_q [TableDepth];
  mrct_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/mrct_ctrl.sv
// Sequencer of the connection table: scans the entry memory, updates entries
// and valid bits, and hands results to the output register. Uses mrct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrct_ctrl #(
  parameter int unsigned TableDepth = mrct_pkg::TABLE_DEPTH,
  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire mrct_pkg::cfg_t       cfg_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire mrct_pkg::item_t      item_i,
  input  wire logic                 out_free_i,
  output logic                      res_valid_o,
  output mrct_pkg::res_t            res_o,
  output logic                      mem_we_o,
  output logic [IdxW-1:0]           mem_waddr_o,
  output mrct_pkg::entry_t          mem_wdata_o,
  output logic                      mem_re_o,
  output logic [IdxW-1:0]           mem_raddr_o,
  input  wire mrct_pkg::entry_t     mem_rdata_i
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_CHECK = 5'b00100,
    S_ACT = 5'b01000,
    S_FLUSH = 5'b10000
  } state_e;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableDepth - 1);

  function automatic logic [3:0] slot_of(input logic [IdxW-1:0] idx);
    logic [IdxW+3:0] ext;
    ext = {4'b0000, idx};
    return ext[3:0];
  endfunction

  state_e state_q, state_d;
  mrct_pkg::item_t item_q, item_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [mrct_pkg::CNT_W-1:0] n_q, n_d;
  logic hit_q, hit_d;
  logic [IdxW-1:0] hit_idx_q, hit_idx_d;
  mrct_pkg::st_e hit_st_q, hit_st_d;
  logic free_q, free_d;
  logic [IdxW-1:0] free_idx_q, free_idx_d;
  logic pend_v_q, pend_v_d;
  mrct_pkg::res_t pend_q, pend_d;
  logic [TableDepth-1:0] valid_q, valid_d;

  logic ent_valid;
  logic [31:0] age;
  logic expire;
  logic is_conn, is_push, is_close;
  logic [3:0] hit_slot;

  assign ent_valid = valid_q[idx_q];
  assign age = item_q.time_now - mem_rdata_i.rx_time;
  assign expire = ent_valid && (mem_rdata_i.status != mrct_pkg::ST_CLOSED) &&
                  (age >= cfg_i.idle_timeout) &&
                  (n_q < mrct_pkg::CNT_W'(mrct_pkg::MAX_RESULTS));
  assign is_conn = item_q.msg_cmd == cfg_i.connect_code;
  assign is_push = item_q.msg_cmd == cfg_i.push_code;
  assign is_close = item_q.msg_cmd == cfg_i.close_code;
  assign hit_slot = hit_q ? slot_of(hit_idx_q) : 4'd0;

  assign in_ready_o = state_q == S_IDLE;
  assign mem_raddr_o = idx_q;

  always_comb begin
    res_o = pend_q;
    res_o.last = state_q == S_FLUSH;
  end

  always_comb begin
    state_d = state_q;
    item_d = item_q;
    idx_d = idx_q;
    n_d = n_q;
    hit_d = hit_q;
    hit_idx_d = hit_idx_q;
    hit_st_d = hit_st_q;
    free_d = free_q;
    free_idx_d = free_idx_q;
    pend_v_d = pend_v_q;
    pend_d = pend_q;
    valid_d = valid_q;
    res_valid_o = 1'b0;
    mem_re_o = 1'b0;
    mem_we_o = 1'b0;
    mem_waddr_o = idx_q;
    mem_wdata_o = mem_rdata_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d = item_i;
          idx_d = '0;
          n_d = '0;
          hit_d = 1'b0;
          free_d = 1'b0;
          pend_v_d = 1'b0;
          case (item_i.opcode)
            mrct_pkg::OP_TICK: begin
              if (cfg_i.timeout_enable && (cfg_i.idle_timeout != 32'd0)) begin
                state_d = S_READ;
              end else begin
                state_d = S_FLUSH;
              end
            end
            mrct_pkg::OP_UNUSED: begin
              pend_d = '{mrct_pkg::ACT_IGNORED, item_i.conn_id, 4'd0, 16'd0, 1'b0};
              pend_v_d = 1'b1;
              state_d = S_FLUSH;
            end
            default: begin
              state_d = S_READ;
            end
          endcase
        end
      end
      S_READ: begin
        mem_re_o = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (!(item_q.opcode == mrct_pkg::OP_TICK && expire && pend_v_q && !out_free_i)) begin
          if (item_q.opcode == mrct_pkg::OP_TICK) begin
            if (expire) begin
              mem_we_o = 1'b1;
              mem_wdata_o = '{mem_rdata_i.id, mrct_pkg::ST_CLOSED, mem_rdata_i.rx_time};
              res_valid_o = pend_v_q;
              pend_d = '{mrct_pkg::ACT_CLOSED, mem_rdata_i.id, slot_of(idx_q), 16'd0, 1'b0};
              pend_v_d = 1'b1;
              n_d = n_q + 1'b1;
            end
          end else begin
            if (ent_valid && !hit_q && (mem_rdata_i.id == item_q.conn_id)) begin
              hit_d = 1'b1;
              hit_idx_d = idx_q;
              hit_st_d = mem_rdata_i.status;
            end
            if (!ent_valid && !free_q) begin
              free_d = 1'b1;
              free_idx_d = idx_q;
            end
          end
          if (idx_q == LastIdx) begin
            state_d = (item_q.opcode == mrct_pkg::OP_TICK) ? S_FLUSH : S_ACT;
          end else begin
            idx_d = idx_q + 1'b1;
            state_d = S_READ;
          end
        end
      end
      S_ACT: begin
        pend_v_d = 1'b1;
        state_d = S_FLUSH;
        if (item_q.opcode == mrct_pkg::OP_RELEASE) begin
          if (hit_q) begin
            valid_d[hit_idx_q] = 1'b0;
            pend_d = '{mrct_pkg::ACT_RELEASED, item_q.conn_id, hit_slot, 16'd0, 1'b0};
          end else begin
            pend_d = '{mrct_pkg::ACT_REL_MISS, item_q.conn_id, 4'd0, 16'd0, 1'b0};
          end
        end else if (is_conn && hit_q && (hit_st_q != mrct_pkg::ST_NEW)) begin
          pend_d = '{mrct_pkg::ACT_BAD_CONNECT, item_q.conn_id, hit_slot, 16'd0, 1'b0};
        end else if (is_conn && !hit_q && !free_q) begin
          pend_d = '{mrct_pkg::ACT_FULL, item_q.conn_id, 4'd0, 16'd0, 1'b0};
        end else if (is_conn && !hit_q) begin
          valid_d[free_idx_q] = 1'b1;
          mem_we_o = 1'b1;
          mem_waddr_o = free_idx_q;
          mem_wdata_o = '{item_q.conn_id, mrct_pkg::ST_OPEN, item_q.time_now};
          pend_d = '{mrct_pkg::ACT_NEW_DELIVER, item_q.conn_id, slot_of(free_idx_q),
                     item_q.payload_length, 1'b0};
        end else if (!hit_q || (hit_st_q == mrct_pkg::ST_CLOSED)) begin
          pend_d = '{mrct_pkg::ACT_DROP, item_q.conn_id, hit_slot, 16'd0, 1'b0};
        end else begin
          mem_we_o = 1'b1;
          mem_waddr_o = hit_idx_q;
          if (is_conn || is_push) begin
            mem_wdata_o = '{item_q.conn_id, mrct_pkg::ST_OPEN, item_q.time_now};
            pend_d = '{mrct_pkg::ACT_DELIVER, item_q.conn_id, hit_slot,
                       item_q.payload_length, 1'b0};
          end else if (is_close) begin
            mem_wdata_o = '{item_q.conn_id, mrct_pkg::ST_CLOSED, item_q.time_now};
            pend_d = '{mrct_pkg::ACT_CLOSED, item_q.conn_id, hit_slot, 16'd0, 1'b0};
          end else begin
            mem_wdata_o = '{item_q.conn_id, mrct_pkg::ST_OPEN, item_q.time_now};
            pend_d = '{mrct_pkg::ACT_IGNORED, item_q.conn_id, hit_slot, 16'd0, 1'b0};
          end
        end
      end
      S_FLUSH: begin
        if (!pend_v_q) begin
          state_d = S_IDLE;
        end else if (out_free_i) begin
          res_valid_o = 1'b1;
          pend_v_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_v_q <= 1'b0;
      valid_q <= '0;
      n_q <= '0;
      idx_q <= '0;
      hit_q <= 1'b0;
      free_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_v_q <= pend_v_d;
      valid_q <= valid_d;
      n_q <= n_d;
      idx_q <= idx_d;
      hit_q <= hit_d;
      free_q <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    hit_idx_q <= hit_idx_d;
    hit_st_q <= hit_st_d;
    free_idx_q <= free_idx_d;
    pend_q <= pend_d;
  end

endmodule

`default_nettype wire
